[hw/rtl/four_neighbour_despeckle_filter_core_assert.svh]
// ----------------------------------------------------------------------------
// despeckle filter assertion macros
// clocked assertions on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef FOUR_NEIGHBOUR_DESPECKLE_FILTER_CORE_ASSERT_SVH
`define FOUR_NEIGHBOUR_DESPECKLE_FILTER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define FNDF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("despeckle assertion failed");
`define FNDF_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("despeckle forbidden condition seen");
`else
`define FNDF_ASSERT(lbl, prop)
`define FNDF_ASSERT_NEVER(lbl, cond)
`endif
`endif

[hw/rtl/fndf_pkg.sv]
// ----------------------------------------------------------------------------
// fndf_pkg
// shared types, constants and the despeckle decision for the filter core
// ----------------------------------------------------------------------------
package fndf_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned ROW_W       = 10;
  localparam int unsigned FWIDTH_W    = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 10;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [FWIDTH_W-1:0] FRAME_WIDTH_RST  = 7'd30;
  localparam logic [ROW_W-1:0]    FRAME_HEIGHT_RST = 10'd20;

  // classification of one pixel, worked out at the front
  typedef struct packed {
    logic has_d;    // pixel of the row above is ready
    logic up2;      // that pixel has an up neighbour
    logic left;     // that pixel has a left neighbour
    logic right;    // that pixel has a right neighbour
    logic l_pres;   // last row: left pixel is ready
    logic l_left;   // last row: that pixel has a left neighbour
    logic f_pres;   // last row: this pixel closes the frame
  } fndf_flags_t;

  function automatic logic [PIX_W-1:0] despeckle(input logic [PIX_W-1:0] center,
                                                 input logic [9:0] sum,
                                                 input logic [2:0] cnt);
    logic [9:0]       scaled;
    logic [10:0]      hi;
    logic [10:0]      lo;
    logic             change;
    logic [20:0]      prod;
    logic [PIX_W-1:0] quot;
    scaled = 10'({2'b00, center} * {7'b0, cnt});
    hi     = {1'b0, scaled} + {8'b0, cnt};
    lo     = {1'b0, sum} + {8'b0, cnt};
    change = ({1'b0, sum} > hi) || (lo < {1'b0, scaled});
    // divide by three through the reciprocal, exact for sums up to 1020
    prod   = {11'b0, sum} * 21'd683;
    case (cnt)
      3'd2:    quot = sum[8:1];
      3'd3:    quot = prod[18:11];
      3'd4:    quot = sum[9:2];
      default: quot = sum[7:0];
    endcase
    return change ? quot : center;
  endfunction

endpackage

[hw/rtl/fndf_ram.sv]
// ----------------------------------------------------------------------------
// fndf_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module fndf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/fndf_queue.sv]
// ----------------------------------------------------------------------------
// fndf_queue
// short first-in first-out queue between the front and the back
// ----------------------------------------------------------------------------
`include "four_neighbour_despeckle_filter_core_assert.svh"

module fndf_queue #(
  parameter int unsigned DataW = 21,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [DataW-1:0] data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  `FNDF_ASSERT(a_no_overflow, (cnt_q == CntW'(Depth)) |-> !push_i)
  `FNDF_ASSERT_NEVER(a_no_underflow, pop_i && (cnt_q == '0))
  `FNDF_ASSERT(a_cnt_up, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))

endmodule

[hw/rtl/fndf_front.sv]
// ----------------------------------------------------------------------------
// fndf_front
// frame registers, raster position tracking and pixel classification
// ----------------------------------------------------------------------------
module fndf_front #(
  parameter int unsigned MaxWidth = 64,
  parameter int unsigned ColW     = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fndf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fndf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [fndf_pkg::PIX_W-1:0]      pixel_in_i,
  output logic                            push_o,
  input  logic                            full_i,
  output logic [fndf_pkg::PIX_W-1:0]      item_pixel_o,
  output logic [ColW-1:0]                 item_col_o,
  output fndf_pkg::fndf_flags_t           item_flags_o
);

  localparam int unsigned CmpW = ((ColW + 1) > fndf_pkg::FWIDTH_W) ? (ColW + 1)
                                                                  : fndf_pkg::FWIDTH_W;

  logic [fndf_pkg::FWIDTH_W-1:0] width_q;
  logic [fndf_pkg::ROW_W-1:0]    height_q;
  logic [fndf_pkg::ROW_W-1:0]    row_q, row_d;
  logic [ColW-1:0]               col_q, col_d;
  logic [CmpW-1:0]               fw_ext, eff_w, col_ext;
  logic [fndf_pkg::ROW_W-1:0]    eff_h;
  logic                          accept, last_row, col_last;

  always_comb begin
    fw_ext = CmpW'(width_q);
    if (fw_ext < CmpW'(2)) begin
      eff_w = CmpW'(2);
    end else if (fw_ext > CmpW'(MaxWidth)) begin
      eff_w = CmpW'(MaxWidth);
    end else begin
      eff_w = fw_ext;
    end
  end

  assign eff_h    = (height_q == '0) ? 10'd1 : height_q;
  assign col_ext  = CmpW'(col_q);
  assign last_row = (row_q == eff_h - 10'd1);
  assign col_last = (col_ext == eff_w - CmpW'(1));
  assign accept   = in_valid_i && !full_i;

  always_comb begin
    item_flags_o.has_d  = (row_q != '0);
    item_flags_o.up2    = (row_q >= 10'd2);
    item_flags_o.left   = (col_q != '0);
    item_flags_o.right  = ((col_ext + CmpW'(1)) < eff_w);
    item_flags_o.l_pres = last_row && (col_q != '0);
    item_flags_o.l_left = last_row && (col_ext >= CmpW'(2));
    item_flags_o.f_pres = last_row && col_last;
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 10'd1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= fndf_pkg::FRAME_WIDTH_RST;
      height_q <= fndf_pkg::FRAME_HEIGHT_RST;
      row_q    <= '0;
      col_q    <= '0;
    end else if (cfg_we_i && (cfg_idx_i == fndf_pkg::REG_FRAME_WIDTH)) begin
      width_q <= cfg_data_i[fndf_pkg::FWIDTH_W-1:0];
      row_q   <= '0;
      col_q   <= '0;
    end else if (cfg_we_i && (cfg_idx_i == fndf_pkg::REG_FRAME_HEIGHT)) begin
      height_q <= cfg_data_i;
      row_q    <= '0;
      col_q    <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign in_stall_o   = full_i;
  assign push_o       = accept;
  assign item_pixel_o = pixel_in_i;
  assign item_col_o   = col_q;

endmodule

[hw/rtl/fndf_back.sv]
// ----------------------------------------------------------------------------
// fndf_back
// line stores and the sequencer that filters and emits up to three pixels
// ----------------------------------------------------------------------------
`include "four_neighbour_despeckle_filter_core_assert.svh"

module fndf_back #(
  parameter int unsigned MaxWidth = 64,
  parameter int unsigned ColW     = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       q_pop_o,
  input  logic [fndf_pkg::PIX_W-1:0] q_pixel_i,
  input  logic [ColW-1:0]            q_col_i,
  input  fndf_pkg::fndf_flags_t      q_flags_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [fndf_pkg::PIX_W-1:0] pixel_out_o,
  output logic                       last_of_run_o,
  output logic                       end_of_frame_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DLY,
    ST_LAST,
    ST_FIN
  } state_e;

  state_e                     state_q;
  logic [fndf_pkg::PIX_W-1:0] pix_q, pprev_q, d_q, dprev_q, l_q;
  logic [ColW-1:0]            col_q;
  fndf_pkg::fndf_flags_t      flags_q;
  logic                       out_valid_q, out_last_q, out_eof_q;
  logic [fndf_pkg::PIX_W-1:0] out_pix_q;

  logic                       out_free, emit, raw_we, filt_we;
  logic [ColW-1:0]            rd_col, rgt_col;
  logic [fndf_pkg::PIX_W-1:0] ctr_rd, rgt_rd, up_rd, center, res;
  logic [9:0]                 sum;
  logic [2:0]                 cnt;

  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign rd_col   = (state_q == ST_IDLE) ? q_col_i : col_q;
  assign rgt_col  = rd_col + 1'b1;
  assign raw_we   = (state_q == ST_DLY) && (!flags_q.has_d || out_free);
  assign filt_we  = (state_q == ST_DLY) && flags_q.has_d && out_free;

  fndf_ram #(.Width(fndf_pkg::PIX_W), .Depth(MaxWidth)) u_raw_ctr (
    .clk_i   (clk_i),
    .we_i    (raw_we),
    .waddr_i (col_q),
    .wdata_i (pix_q),
    .raddr_i (rd_col),
    .rdata_o (ctr_rd)
  );

  fndf_ram #(.Width(fndf_pkg::PIX_W), .Depth(MaxWidth)) u_raw_rgt (
    .clk_i   (clk_i),
    .we_i    (raw_we),
    .waddr_i (col_q),
    .wdata_i (pix_q),
    .raddr_i (rgt_col),
    .rdata_o (rgt_rd)
  );

  fndf_ram #(.Width(fndf_pkg::PIX_W), .Depth(MaxWidth)) u_filt (
    .clk_i   (clk_i),
    .we_i    (filt_we),
    .waddr_i (col_q),
    .wdata_i (res),
    .raddr_i (rd_col),
    .rdata_o (up_rd)
  );

  always_comb begin
    center = '0;
    sum    = '0;
    cnt    = 3'd1;
    emit   = 1'b0;
    case (state_q)
      ST_DLY: begin
        center = ctr_rd;
        sum    = {2'b00, pix_q}
               + (flags_q.up2   ? {2'b00, up_rd}  : 10'd0)
               + (flags_q.left  ? {2'b00, d_q}    : 10'd0)
               + (flags_q.right ? {2'b00, rgt_rd} : 10'd0);
        cnt    = 3'd1 + {2'b00, flags_q.up2} + {2'b00, flags_q.left}
               + {2'b00, flags_q.right};
        emit   = flags_q.has_d && out_free;
      end
      ST_LAST: begin
        center = pprev_q;
        sum    = {2'b00, pix_q}
               + (flags_q.has_d  ? {2'b00, dprev_q} : 10'd0)
               + (flags_q.l_left ? {2'b00, l_q}     : 10'd0);
        cnt    = 3'd1 + {2'b00, flags_q.has_d} + {2'b00, flags_q.l_left};
        emit   = out_free;
      end
      ST_FIN: begin
        center = pix_q;
        sum    = {2'b00, l_q} + (flags_q.has_d ? {2'b00, d_q} : 10'd0);
        cnt    = 3'd1 + {2'b00, flags_q.has_d};
        emit   = out_free;
      end
      default: begin
        center = '0;
      end
    endcase
  end

  assign res = fndf_pkg::despeckle(center, sum, cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pix_q       <= '0;
      pprev_q     <= '0;
      col_q       <= '0;
      flags_q     <= '0;
      d_q         <= '0;
      dprev_q     <= '0;
      l_q         <= '0;
      out_valid_q <= 1'b0;
      out_pix_q   <= '0;
      out_last_q  <= 1'b0;
      out_eof_q   <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        out_pix_q   <= res;
        out_eof_q   <= (state_q == ST_FIN);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            pprev_q <= pix_q;
            pix_q   <= q_pixel_i;
            col_q   <= q_col_i;
            flags_q <= q_flags_i;
            state_q <= ST_DLY;
          end
        end
        ST_DLY: begin
          if (!flags_q.has_d || out_free) begin
            if (flags_q.has_d) begin
              dprev_q    <= d_q;
              d_q        <= res;
              out_last_q <= !(flags_q.l_pres || flags_q.f_pres);
            end
            if (flags_q.l_pres) begin
              state_q <= ST_LAST;
            end else if (flags_q.f_pres) begin
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_LAST: begin
          if (out_free) begin
            l_q        <= res;
            out_last_q <= !flags_q.f_pres;
            state_q    <= flags_q.f_pres ? ST_FIN : ST_IDLE;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_last_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = out_pix_q;
  assign last_of_run_o  = out_last_q;
  assign end_of_frame_o = out_eof_q;

  `FNDF_ASSERT(a_last_needs_l, (state_q == ST_LAST) |-> flags_q.l_pres)
  `FNDF_ASSERT(a_fin_needs_f, (state_q == ST_FIN) |-> flags_q.f_pres)
  `FNDF_ASSERT(a_eof_is_last, (out_valid_q && out_eof_q) |-> out_last_q)

endmodule

[hw/rtl/four_neighbour_despeckle_filter_core.sv]
// ----------------------------------------------------------------------------
// four_neighbour_despeckle_filter_core
// raster despeckle filter: four-neighbour mean replaces outlying pixels
//
//   channel   signals                                          direction
//   config    cfg_we_i cfg_idx_i cfg_data_i                    in, write only
//   pixel in  in_valid_i in_stall_o pixel_in_i                 in
//   pixel out out_valid_o out_stall_i pixel_out_o
//             last_of_run_o end_of_frame_o                     out
//
// an item passes through the back sequencer's idle and delay states, then one
// more state per extra last-row result, all through the single shared filter unit
// results trail the input by one image row; a two-entry queue decouples
// the input side from the sequencer and a result register from the output
// reset clears the frame position and registers; line stores are not cleared
// ----------------------------------------------------------------------------
module four_neighbour_despeckle_filter_core #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fndf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fndf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [fndf_pkg::PIX_W-1:0]      pixel_in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fndf_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                            last_of_run_o,
  output logic                            end_of_frame_o
);

  localparam int unsigned ColW   = $clog2(MAX_WIDTH);
  localparam int unsigned FlagsW = $bits(fndf_pkg::fndf_flags_t);
  localparam int unsigned ItemW  = fndf_pkg::PIX_W + ColW + FlagsW;

  logic                       push, full, q_valid, q_pop;
  logic [fndf_pkg::PIX_W-1:0] item_pixel;
  logic [ColW-1:0]            item_col;
  fndf_pkg::fndf_flags_t      item_flags;
  logic [ItemW-1:0]           q_in, q_out;
  fndf_pkg::fndf_flags_t      head_flags;

  fndf_front #(.MaxWidth(MAX_WIDTH), .ColW(ColW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_in_i   (pixel_in_i),
    .push_o       (push),
    .full_i       (full),
    .item_pixel_o (item_pixel),
    .item_col_o   (item_col),
    .item_flags_o (item_flags)
  );

  assign q_in = {item_pixel, item_col, item_flags};

  fndf_queue #(.DataW(ItemW), .Depth(fndf_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign head_flags = q_out[FlagsW-1:0];

  fndf_back #(.MaxWidth(MAX_WIDTH), .ColW(ColW)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_pixel_i      (q_out[ItemW-1 -: fndf_pkg::PIX_W]),
    .q_col_i        (q_out[FlagsW +: ColW]),
    .q_flags_i      (head_flags),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_out_o    (pixel_out_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule

[tb/four_neighbour_despeckle_filter_core_test.sv]
// ----------------------------------------------------------------------------
// four_neighbour_despeckle_filter_core_test
// drives raster frames of many sizes through the despeckle core, with random
// idle cycles on the pixel input and random stalls on the result side; a
// directed table covers edge sizes, register handling and plain outliers,
// then random frames follow; every result transfer is checked field by field
// against an in-order queue filled by a bit-exact model of the filter
// ----------------------------------------------------------------------------
module four_neighbour_despeckle_filter_core_test;
  import fndf_pkg::*;

  localparam int unsigned MAX_COLS     = 64;
  localparam int          ITEMS        = 170;
  localparam int          DRAIN_CYCLES = 24;
  localparam int          N_DIRECTED   = 25;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum logic {STEP_PIXEL, STEP_REG} step_e;
  typedef enum int {STYLE_NOISE, STYLE_SMOOTH, STYLE_BINARY} pixel_style_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             eof;
  } pixel_result_t;

  typedef struct {
    step_e                 kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    bit                    typed;
    int                    count;
    logic [PIX_W-1:0]      res_a;
    logic [PIX_W-1:0]      res_b;
    bit                    eof;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [PIX_W-1:0]      pixel_in_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [PIX_W-1:0]      pixel_out_o;
  logic                  last_of_run_o;
  logic                  end_of_frame_o;

  pixel_result_t expected_pixels[$];
  int            mismatches = 0;
  int            calm_in = 0;
  int            calm_out = 0;
  int            random_items;

  // filter state as the core should hold it
  logic [PIX_W-1:0]    raw_row  [MAX_COLS];
  logic [PIX_W-1:0]    filt_row [MAX_COLS];
  logic [PIX_W-1:0]    left_filt;
  int unsigned         row_pos;
  int unsigned         col_pos;
  logic [FWIDTH_W-1:0] width_reg;
  logic [ROW_W-1:0]    height_reg;

  // kind, index, data or pixel, typed, result count, results, end of frame
  stim_row_t directed [N_DIRECTED] = '{
    '{STEP_PIXEL, REG_FRAME_WIDTH,  10'd0,   1'b1, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_REG,   REG_FRAME_WIDTH,  10'd0,   1'b0, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_REG,   REG_FRAME_HEIGHT, 10'd0,   1'b0, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  10'd0,   1'b1, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  10'd255, 1'b1, 2, 8'd255, 8'd255, 1'b1},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  10'd255, 1'b1, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  10'd0,   1'b1, 2, 8'd0,   8'd0,   1'b1},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  10'd7,   1'b1, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  10'd8,   1'b1, 2, 8'd7,   8'd8,   1'b1},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  10'd7,   1'b1, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_REG,   REG_SPARE_LO,     10'h3ff, 1'b0, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  10'd9,   1'b1, 2, 8'd9,   8'd9,   1'b1},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  10'd200, 1'b1, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_REG,   REG_SPARE_HI,     10'h2aa, 1'b0, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  10'd201, 1'b1, 2, 8'd200, 8'd201, 1'b1},
    '{STEP_REG,   REG_FRAME_WIDTH,  10'd1,   1'b0, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_REG,   REG_FRAME_HEIGHT, 10'h3ff, 1'b0, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_REG,   REG_FRAME_WIDTH,  10'h3ff, 1'b0, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  10'd255, 1'b1, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_REG,   REG_FRAME_WIDTH,  10'h082, 1'b0, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_REG,   REG_FRAME_HEIGHT, 10'd2,   1'b0, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  10'd0,   1'b0, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  10'd255, 1'b0, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  10'd255, 1'b0, 0, 8'd0,   8'd0,   1'b0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  10'd0,   1'b0, 0, 8'd0,   8'd0,   1'b0}
  };

  four_neighbour_despeckle_filter_core #(
    .MAX_WIDTH(MAX_COLS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_in_i    (pixel_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_out_o   (pixel_out_o),
    .last_of_run_o (last_of_run_o),
    .end_of_frame_o(end_of_frame_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned frame_cols();
    if (width_reg < 2) return 2;
    if (width_reg > MAX_COLS) return MAX_COLS;
    return int'(width_reg);
  endfunction

  function automatic int unsigned frame_rows();
    return (height_reg == '0) ? 1 : int'(height_reg);
  endfunction

  // keep the centre unless the neighbour mean is off by more than one
  function automatic logic [PIX_W-1:0] smooth_value(input int unsigned centre,
                                                    input int unsigned sum,
                                                    input int unsigned cnt);
    int unsigned scaled;
    scaled = centre * cnt;
    if (cnt == 0) return PIX_W'(centre);
    if (sum > scaled + cnt || sum + cnt < scaled) return PIX_W'(sum / cnt);
    return PIX_W'(centre);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FRAME_WIDTH:  width_reg = data[FWIDTH_W-1:0];
      REG_FRAME_HEIGHT: height_reg = data[ROW_W-1:0];
      default: return;
    endcase
    row_pos   = 0;
    col_pos   = 0;
    left_filt = '0;
  endfunction

  // one pixel transfer in, queues the filtered pixels it releases
  function automatic int filter_pixel(input logic [PIX_W-1:0] p);
    int unsigned   w, h, i, j, c, sum, cnt;
    logic [PIX_W-1:0] v;
    pixel_result_t out_px [3];
    int            n;
    w = frame_cols();
    h = frame_rows();
    i = row_pos;
    j = col_pos;
    n = 0;
    if (i >= h || j >= w) begin
      i = 0;
      j = 0;
    end
    if (i >= 1) begin
      sum = p;
      cnt = 1;
      if (i >= 2) begin
        sum += filt_row[j];
        cnt++;
      end
      if (j > 0) begin
        sum += left_filt;
        cnt++;
      end
      if (j + 1 < w) begin
        sum += raw_row[j + 1];
        cnt++;
      end
      v = smooth_value(raw_row[j], sum, cnt);
      filt_row[j] = v;
      left_filt   = v;
      out_px[n]   = '{v, 1'b0, 1'b0};
      n++;
    end
    raw_row[j] = p;
    if (i == h - 1) begin
      if (j >= 1) begin
        c   = j - 1;
        sum = p;
        cnt = 1;
        if (i >= 1) begin
          sum += filt_row[c];
          cnt++;
        end
        if (c >= 1) begin
          sum += filt_row[c - 1];
          cnt++;
        end
        v = smooth_value(raw_row[c], sum, cnt);
        filt_row[c] = v;
        out_px[n]   = '{v, 1'b0, 1'b0};
        n++;
      end
      if (j == w - 1) begin
        sum = filt_row[j - 1];
        cnt = 1;
        if (i >= 1) begin
          sum += filt_row[j];
          cnt++;
        end
        v = smooth_value(p, sum, cnt);
        filt_row[j] = v;
        out_px[n]   = '{v, 1'b0, 1'b1};
        n++;
      end
    end
    if (n > 0) out_px[n - 1].last = 1'b1;
    for (int k = 0; k < n; k++) expected_pixels.push_back(out_px[k]);
    j++;
    if (j >= w) begin
      j         = 0;
      left_filt = '0;
      i++;
      if (i >= h) i = 0;
    end
    row_pos = i;
    col_pos = j;
    return n;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) calm = $urandom_range(10, 40);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [PIX_W-1:0] gen_pixel(input pixel_style_e style,
                                                 inout int level);
    case (style)
      STYLE_SMOOTH: begin
        if ($urandom_range(0, 9) == 0) return PIX_W'($urandom_range(0, 255));
        level += $urandom_range(0, 4) - 2;
        if (level < 0) level = 0;
        if (level > 255) level = 255;
        return PIX_W'(level);
      end
      STYLE_BINARY: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] value, output int produced);
    int gap;
    gap = pick_gap(calm_in);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    produced = filter_pixel(value);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic send_frame(input int unsigned count);
    pixel_style_e style;
    int           level;
    int           produced;
    style = pixel_style_e'($urandom_range(0, 2));
    level = $urandom_range(0, 255);
    for (int k = 0; k < count; k++) begin
      // spare register index mid-frame, must not restart the frame
      if ($urandom_range(0, 99) < 3)
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                  CFG_DATA_W'($urandom_range(0, 1023)));
      push_pixel(gen_pixel(style, level), produced);
      random_items++;
    end
  endtask

  task automatic write_width(input int unsigned w);
    write_reg(REG_FRAME_WIDTH, {3'($urandom_range(0, 7)), FWIDTH_W'(w)});
  endtask

  initial begin
    int          produced;
    int          phase;
    int          pick;
    int unsigned w, h;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_FRAME_WIDTH;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    pixel_in_i  <= '0;
    width_reg   = FRAME_WIDTH_RST;
    height_reg  = FRAME_HEIGHT_RST;
    row_pos     = 0;
    col_pos     = 0;
    left_filt   = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < N_DIRECTED; k++) begin
      if (directed[k].kind == STEP_REG) begin
        write_reg(directed[k].idx, directed[k].value);
      end else begin
        push_pixel(directed[k].value[PIX_W-1:0], produced);
        if (directed[k].typed) begin
          repeat (produced) void'(expected_pixels.pop_back());
          for (int r = 0; r < directed[k].count; r++)
            expected_pixels.push_back('{(r == 0) ? directed[k].res_a : directed[k].res_b,
                                        r == directed[k].count - 1,
                                        r == directed[k].count - 1 && directed[k].eof});
        end
      end
    end

    random_items = 0;
    phase        = 0;
    while (random_items < ITEMS || phase < 4) begin
      case (phase)
        1: begin
          // widest row, clamped from any value above the maximum
          write_reg(REG_FRAME_HEIGHT, 10'd1);
          write_width($urandom_range(0, 1) ? MAX_COLS : $urandom_range(MAX_COLS, 127));
          send_frame(frame_cols() * frame_rows());
        end
        3: begin
          // tallest frame, left unfinished
          write_width(2);
          write_reg(REG_FRAME_HEIGHT, 10'h3ff);
          send_frame(2 * $urandom_range(6, 12) + $urandom_range(0, 1));
        end
        default: begin
          w    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 8);
          h    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
          pick = $urandom_range(0, 3);
          if (frame_cols() > 16 || frame_rows() > 8) pick = 2;
          if (pick != 1) write_width(w);
          if (pick != 0) write_reg(REG_FRAME_HEIGHT, ROW_W'(h));
          repeat ($urandom_range(1, 2)) send_frame(frame_cols() * frame_rows());
          if ($urandom_range(0, 4) == 0)
            send_frame($urandom_range(1, frame_cols() * frame_rows() - 1));
        end
      endcase
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    int run;
    int hold;
    out_stall_i <= 1'b0;
    forever begin
      run  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      hold = pick_gap(calm_out);
      repeat (run) @(posedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with none expected, pixel_out %0d",
                 $time, pixel_out_o);
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_out_o !== want.pixel) begin
          mismatches++;
          $display("%0t: pixel_out expected %0d, actual %0d", $time, want.pixel, pixel_out_o);
        end
        if (last_of_run_o !== want.last) begin
          mismatches++;
          $display("%0t: last_of_run expected %0b, actual %0b",
                   $time, want.last, last_of_run_o);
        end
        if (end_of_frame_o !== want.eof) begin
          mismatches++;
          $display("%0t: end_of_frame expected %0b, actual %0b",
                   $time, want.eof, end_of_frame_o);
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule

[four_neighbour_despeckle_filter_core.f]
+incdir+hw/rtl
hw/rtl/fndf_pkg.sv
hw/rtl/fndf_ram.sv
hw/rtl/fndf_queue.sv
hw/rtl/fndf_front.sv
hw/rtl/fndf_back.sv
hw/rtl/four_neighbour_despeckle_filter_core.sv
tb/four_neighbour_despeckle_filter_core_test.sv
